[rtl/stu_pkg.sv]
// Shared types and constants for the signature table update block.
package stu_pkg;

  // Fixed field widths of the two channels and of the hash
  localparam int PAGE_W   = 52;
  localparam int OFF_W    = 6;
  localparam int OUT_SIG_W = 12;
  localparam int DELTA_W  = 7;
  localparam int HASH_W   = 64;

  // Multiplier of the final hash step
  localparam logic [31:0] MIX_MULT = 32'd2654435761;

  // Controller to datapath commands; at most one is high in a cycle
  typedef struct packed {
    logic take;       // input channel ready
    logic clr;        // write one reset row during the clearing pass
    logic mix_step;   // two steps of the integer mix
    logic mul0;       // low half product
    logic mul1;       // high half product, stage low half
    logic mul2;       // combine halves
    logic set_mask;   // set index from low hash bits
    logic mod_step;   // four hash bits of the set remainder
    logic rd;         // read the set row
    logic look;       // tag compare
    logic pick;       // way selection
    logic upd;        // write row back, load result register
  } stu_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_valid;
    logic clr_last;
    logic mix_last;
    logic mod_last;
    logic set_pow2;
    logic out_free;
  } stu_sts_t;

endpackage

[rtl/stu_if.sv]
// Valid/ready channel interfaces for page accesses and table results.
interface stu_access_if;
  import stu_pkg::*;
  logic                valid;
  logic                ready;
  logic [PAGE_W-1:0]   page_number;
  logic [OFF_W-1:0]    block_offset;

  modport source (output valid, output page_number, output block_offset, input ready);
  modport sink   (input valid, input page_number, input block_offset, output ready);
endinterface

interface stu_result_if;
  import stu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      table_hit;
  logic [OUT_SIG_W-1:0]      previous_signature;
  logic [OUT_SIG_W-1:0]      new_signature;
  logic signed [DELTA_W-1:0] block_delta;

  modport source (output valid, output table_hit, output previous_signature,
                  output new_signature, output block_delta, input ready);
  modport sink   (input valid, input table_hit, input previous_signature,
                  input new_signature, input block_delta, output ready);
endinterface

[rtl/stu_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module stu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/stu_ctrl.sv]
// Sequencer for the signature table: clearing pass, hash, lookup, update.
module stu_ctrl
  import stu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  stu_sts_t  sts,
  output stu_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_CLEAR = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_MIX   = 11'b00000000100,
    S_MUL0  = 11'b00000001000,
    S_MUL1  = 11'b00000010000,
    S_MUL2  = 11'b00000100000,
    S_MOD   = 11'b00001000000,
    S_READ  = 11'b00010000000,
    S_LOOK  = 11'b00100000000,
    S_PICK  = 11'b01000000000,
    S_WRITE = 11'b10000000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and command decode
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) state_next = S_MIX;
      end
      S_MIX: begin
        cmd.mix_step = 1'b1;
        if (sts.mix_last) state_next = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0   = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        if (sts.set_pow2) begin
          cmd.set_mask = 1'b1;
          state_next   = S_READ;
        end else begin
          cmd.mod_step = 1'b1;
          if (sts.mod_last) state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_LOOK;
      end
      S_LOOK: begin
        cmd.look   = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        cmd.pick   = 1'b1;
        state_next = S_WRITE;
      end
      S_WRITE: begin
        // hold until the result register is free
        if (sts.out_free) begin
          cmd.upd    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

endmodule

[rtl/stu_dp.sv]
// Datapath: page hash, set row lookup, way selection, row update, result register.
module stu_dp
  import stu_pkg::*;
#(
  parameter int SETS            = 64,
  parameter int WAYS            = 4,
  parameter int TAG_BITS        = 16,
  parameter int SIGNATURE_BITS  = 12,
  parameter int SIGNATURE_SHIFT = 3,
  parameter int DELTA_CODE_BITS = 7
) (
  input  logic      clk,
  input  logic      rst,
  input  stu_cmd_t  cmd,
  output stu_sts_t  sts,
  stu_access_if.sink   access,
  stu_result_if.source result
);

  localparam int SET_IDX_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W     = WAY_W;
  localparam int CODE_W    = (DELTA_CODE_BITS > 7) ? DELTA_CODE_BITS : 7;
  localparam int REM_W     = SET_IDX_W + 4;
  localparam bit SETS_POW2 = (SETS & (SETS - 1)) == 0;

  // Entry layout inside a row, lowest field first
  localparam int AGE_LO  = 0;
  localparam int OFF_LO  = AGE_LO + AGE_W;
  localparam int SIG_LO  = OFF_LO + OFF_W;
  localparam int TAG_LO  = SIG_LO + SIGNATURE_BITS;
  localparam int VLD_POS = TAG_LO + TAG_BITS;
  localparam int ENTRY_W = VLD_POS + 1;
  localparam int ROW_W   = WAYS * ENTRY_W;

  localparam logic [SET_IDX_W-1:0] SET_MASK = SET_IDX_W'(SETS - 1);
  localparam logic [REM_W-1:0]     SETS_R   = REM_W'(SETS);
  localparam logic [AGE_W-1:0]     AGE_OLD  = AGE_W'(WAYS - 1);
  localparam logic [CODE_W-1:0]    NEG_FLAG = CODE_W'(1) << (DELTA_CODE_BITS - 1);

  // Two steps of the integer mix per round
  function automatic logic [HASH_W-1:0] mix_round(input logic [HASH_W-1:0] k,
                                                  input logic [1:0] r);
    logic [HASH_W-1:0] a;
    logic [HASH_W-1:0] m;
    begin
      unique case (r)
        2'd0: begin a = k + (k << 12); m = a ^ (a >> 22); end
        2'd1: begin a = k + (k << 4);  m = a ^ (a >> 9);  end
        2'd2: begin a = k + (k << 10); m = a ^ (a >> 2);  end
        2'd3: begin a = k + (k << 7);  m = a ^ (a >> 12); end
      endcase
      return m;
    end
  endfunction

  // Control registers
  logic [SET_IDX_W-1:0] set_idx;
  logic [1:0]           round;
  logic [3:0]           mod_cnt;
  logic                 out_valid;

  // Payload registers
  logic [HASH_W-1:0]    key;
  logic [HASH_W-1:0]    prod;
  logic [HASH_W-1:0]    acc;
  logic [OFF_W-1:0]     off_q;
  logic [TAG_BITS-1:0]  ptag;
  logic [WAYS-1:0]      hit_vec, inv_vec, old_vec;
  logic [WAY_W-1:0]     way_q;
  logic                 hit_q;
  logic                 out_hit;
  logic [OUT_SIG_W-1:0] out_prev, out_new;
  logic [DELTA_W-1:0]   out_delta;

  logic [ROW_W-1:0]     rdata, row_clr, row_upd, wdata;
  logic                 accept;
  logic [31:0]          mul_a;
  logic [REM_W-1:0]     rem_next;

  assign accept       = access.valid & cmd.take;
  assign access.ready = cmd.take;

  assign sts.in_valid = access.valid;
  assign sts.clr_last = set_idx == SET_MASK;
  assign sts.mix_last = round == 2'd3;
  assign sts.mod_last = mod_cnt == 4'd15;
  assign sts.set_pow2 = SETS_POW2;
  assign sts.out_free = !out_valid || result.ready;

  // Shared 32x32 multiplier: low half of the shifted key, then the high half
  assign mul_a = cmd.mul1 ? 32'(key[HASH_W-1:35]) : key[34:3];

  // Remainder step of the set index, four hash bits per cycle
  always_comb begin
    rem_next = {set_idx, acc[HASH_W-1 -: 4]};
    for (int b = 3; b >= 0; b--) begin
      if (rem_next >= (SETS_R << b)) rem_next = rem_next - (SETS_R << b);
    end
  end

  // Counters, set index and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      set_idx   <= '0;
      round     <= '0;
      mod_cnt   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr) set_idx <= set_idx + SET_IDX_W'(1);
      if (accept) round <= '0;
      else if (cmd.mix_step) round <= round + 2'd1;
      if (cmd.mul2) begin
        set_idx <= '0;
        mod_cnt <= '0;
      end
      if (cmd.set_mask) set_idx <= acc[SET_IDX_W-1:0] & SET_MASK;
      if (cmd.mod_step) begin
        set_idx <= rem_next[SET_IDX_W-1:0];
        mod_cnt <= mod_cnt + 4'd1;
      end
      if (cmd.upd) out_valid <= 1'b1;
      else if (result.ready) out_valid <= 1'b0;
    end
  end

  // Hash pipeline registers
  always_ff @(posedge clk) begin
    if (accept) begin
      key   <= HASH_W'(access.page_number);
      off_q <= access.block_offset;
      ptag  <= access.page_number[TAG_BITS-1:0];
    end else if (cmd.mix_step) begin
      key <= mix_round(key, round);
    end
    if (cmd.mul0 || cmd.mul1) prod <= HASH_W'(mul_a) * HASH_W'(MIX_MULT);
    if (cmd.mul1) acc <= prod;
    else if (cmd.mul2) acc <= acc + {prod[31:0], 32'd0};
    else if (cmd.mod_step) acc <= acc << 4;
  end

  // Set row storage
  assign wdata = cmd.clr ? row_clr : row_upd;

  stu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.clr | cmd.upd),
    .waddr (set_idx),
    .wdata (wdata),
    .re    (cmd.rd),
    .raddr (set_idx),
    .rdata (rdata)
  );

  // Reset row: everything zero, ages equal to the way number
  always_comb begin
    row_clr = '0;
    for (int w = 0; w < WAYS; w++) begin
      row_clr[w*ENTRY_W + AGE_LO +: AGE_W] = AGE_W'(w);
    end
  end

  // Tag compare and victim candidates per way
  always_ff @(posedge clk) begin
    if (cmd.look) begin
      for (int w = 0; w < WAYS; w++) begin
        hit_vec[w] <= rdata[w*ENTRY_W + VLD_POS] &&
                      (rdata[w*ENTRY_W + TAG_LO +: TAG_BITS] == ptag);
        inv_vec[w] <= !rdata[w*ENTRY_W + VLD_POS];
        old_vec[w] <= rdata[w*ENTRY_W + AGE_LO +: AGE_W] == AGE_OLD;
      end
    end
  end

  // Way selection: lowest hitting way, else lowest invalid, else the oldest
  logic [WAY_W-1:0] hit_way, inv_way, old_way;

  always_comb begin
    hit_way = '0;
    inv_way = '0;
    old_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (inv_vec[w]) inv_way = WAY_W'(w);
      if (old_vec[w]) old_way = WAY_W'(w);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      hit_q <= |hit_vec;
      way_q <= (|hit_vec) ? hit_way : ((|inv_vec) ? inv_way : old_way);
    end
  end

  // Update of the selected entry and the ages
  logic [AGE_W-1:0]          sel_age, age_w;
  logic [OFF_W-1:0]          sel_off;
  logic [SIGNATURE_BITS-1:0] sel_sig, sig_new;
  logic [DELTA_W-1:0]        delta, delta_neg;
  logic                      delta_nz;
  logic [CODE_W-1:0]         code;
  logic [SIGNATURE_BITS+CODE_W-1:0] fold;
  logic [SIGNATURE_BITS+OUT_SIG_W-1:0] prev_ext, new_ext;

  assign sel_age   = rdata[way_q*ENTRY_W + AGE_LO +: AGE_W];
  assign sel_off   = rdata[way_q*ENTRY_W + OFF_LO +: OFF_W];
  assign sel_sig   = rdata[way_q*ENTRY_W + SIG_LO +: SIGNATURE_BITS];
  assign delta     = {1'b0, off_q} - {1'b0, sel_off};
  assign delta_neg = -delta;
  assign delta_nz  = delta != '0;

  // Sign-magnitude delta code folded into the signature
  assign code    = delta[DELTA_W-1] ? CODE_W'(delta_neg[OFF_W-1:0]) + NEG_FLAG
                                    : CODE_W'(delta[OFF_W-1:0]);
  assign fold    = ({{CODE_W{1'b0}}, sel_sig} << SIGNATURE_SHIFT) ^
                   {{SIGNATURE_BITS{1'b0}}, code};
  assign sig_new = fold[SIGNATURE_BITS-1:0];

  always_comb begin
    row_upd = rdata;
    for (int w = 0; w < WAYS; w++) begin
      age_w = rdata[w*ENTRY_W + AGE_LO +: AGE_W];
      if (WAY_W'(w) == way_q) begin
        row_upd[w*ENTRY_W + AGE_LO +: AGE_W] = '0;
        if (!hit_q) begin
          row_upd[w*ENTRY_W + VLD_POS]                   = 1'b1;
          row_upd[w*ENTRY_W + TAG_LO +: TAG_BITS]        = ptag;
          row_upd[w*ENTRY_W + SIG_LO +: SIGNATURE_BITS]  = '0;
          row_upd[w*ENTRY_W + OFF_LO +: OFF_W]           = off_q;
        end else if (delta_nz) begin
          row_upd[w*ENTRY_W + SIG_LO +: SIGNATURE_BITS]  = sig_new;
          row_upd[w*ENTRY_W + OFF_LO +: OFF_W]           = off_q;
        end
      end else if (age_w < sel_age) begin
        row_upd[w*ENTRY_W + AGE_LO +: AGE_W] = age_w + AGE_W'(1);
      end
    end
  end

  // Result register
  assign prev_ext = {{OUT_SIG_W{1'b0}}, sel_sig};
  assign new_ext  = {{OUT_SIG_W{1'b0}}, sig_new};

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      out_hit   <= hit_q;
      out_prev  <= (hit_q && delta_nz) ? prev_ext[OUT_SIG_W-1:0] : '0;
      out_new   <= (hit_q && delta_nz) ? new_ext[OUT_SIG_W-1:0] : '0;
      out_delta <= hit_q ? delta : '0;
    end
  end

  assign result.valid              = out_valid;
  assign result.table_hit          = out_hit;
  assign result.previous_signature = out_prev;
  assign result.new_signature      = out_new;
  assign result.block_delta        = out_delta;

endmodule

[rtl/signature_table_update.sv]
// Signature table update: top level joining the sequencer and the datapath.
//
//   channel  dir  fields                                             transfer
//   access   in   page_number[51:0], block_offset[5:0]               valid & ready
//   result   out  table_hit, previous_signature[11:0],
//                 new_signature[11:0], block_delta[6:0] (signed)     valid & ready
//
// One access at a time: a new access is taken only after the last one has loaded
// the result register. When SETS is not a power of two, the remainder of the
// hash by SETS takes 16 radix-16 steps in place of the mask.
// The hash itself takes 4 mix rounds, then a low half product, a high half product
// and a combine step on the shared 32x32 multiplier. After reset a clearing pass
// writes every set row, with access not ready. A held result does not block the
// next access; only the row write waits while the result register is still full.
module signature_table_update
  import stu_pkg::*;
#(
  parameter int SETS            = 64,
  parameter int WAYS            = 4,
  parameter int TAG_BITS        = 16,
  parameter int SIGNATURE_BITS  = 12,
  parameter int SIGNATURE_SHIFT = 3,
  parameter int DELTA_CODE_BITS = 7
) (
  input logic          clk,
  input logic          rst,
  stu_access_if.sink   access,
  stu_result_if.source result
);

  stu_cmd_t cmd;
  stu_sts_t sts;

  // Sequencer
  stu_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Hash, table and result datapath
  stu_dp #(
    .SETS            (SETS),
    .WAYS            (WAYS),
    .TAG_BITS        (TAG_BITS),
    .SIGNATURE_BITS  (SIGNATURE_BITS),
    .SIGNATURE_SHIFT (SIGNATURE_SHIFT),
    .DELTA_CODE_BITS (DELTA_CODE_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sts    (sts),
    .access (access),
    .result (result)
  );

  // The sequencer drives one command at a time
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command in a cycle");

  // An accepted access keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (access.valid && access.ready) |=> !access.ready)
    else $error("access ready right after a transfer");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.upd |-> (!result.valid || result.ready))
    else $error("result register overwritten");

  // A new result appears only from a row update
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(cmd.upd))
    else $error("result valid without an update");

endmodule
